// ===== rtl/core/playfair_pair_cipher_defines.svh =====
// Assertion macros used by the checker of the Playfair pair cipher.
`ifndef PLAYFAIR_PAIR_CIPHER_DEFINES_SVH
`define PLAYFAIR_PAIR_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst is high.
`define PFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfc check failed");

// Next-cycle implication, sampled on clk and held off while rst is high.
`define PFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfc check failed");

`endif

// ===== rtl/core/pfc_pkg.sv =====
// Types, constants and helper functions of the Playfair pair cipher.
package pfc_pkg;

  localparam logic [2:0] SIDE        = 3'd5;
  localparam logic [2:0] LAST_RC     = 3'd4;
  localparam logic [4:0] CELLS       = 5'd25;
  localparam int         CELL_DEPTH  = 25;
  localparam int         LETTER_DEPTH = 26;
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_Z    = 5'd25;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_LETTER  = 3'd1;
  localparam logic [2:0] OP_FINISH  = 3'd2;
  localparam logic [2:0] OP_ENCRYPT = 3'd3;
  localparam logic [2:0] OP_DECRYPT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_RESULT,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic clear_key;
    logic place_key;
    logic fill_begin;
    logic fill_step;
    logic pair_begin;
    logic encrypt;
    logic cell_read;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic key_ready;
    logic fill_last;
  } stat_t;

  // Codes above Z saturate to Z, and J folds onto I.
  function automatic logic [4:0] clean_letter(input logic [4:0] v);
    logic [4:0] l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    if (l == LETTER_J) begin
      l = LETTER_I;
    end
    return l;
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] c;
    c = p - cell_index(pos_row(p), 3'd0);
    return c[2:0];
  endfunction

  // One step along a row or column, wrapping around the square.
  function automatic logic [2:0] step_rc(input logic [2:0] x, input logic enc);
    logic [2:0] y;
    if (enc) begin
      y = (x >= LAST_RC) ? 3'd0 : x + 3'd1;
    end else begin
      y = (x == 3'd0) ? LAST_RC : x - 3'd1;
    end
    return y;
  endfunction

endpackage

// ===== rtl/core/pfc_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/pfc_datapath.sv =====
// Datapath: key state, position and square memories, and pair transform.
module pfc_datapath (
  input  logic           clk,
  input  logic           rst,
  input  pfc_pkg::cmd_t  cmd,
  input  logic [4:0]     letter_a,
  input  logic [4:0]     letter_b,
  output pfc_pkg::stat_t stat,
  output logic           done,
  output logic [4:0]     out_a,
  output logic [4:0]     out_b,
  output logic           status
);
  import pfc_pkg::*;

  logic [25:0] used_letters;
  logic [4:0]  fill_count;
  logic        key_ready;
  logic [4:0]  fill_k;
  logic        dir_enc;

  logic [4:0]  a_clean;
  logic [4:0]  b_clean;
  logic [4:0]  place_letter;
  logic        do_place;
  logic [4:0]  pos_a;
  logic [4:0]  pos_b;
  logic [2:0]  ra, ca, rb, cb;
  logic [4:0]  cell_a;
  logic [4:0]  cell_b;
  logic [4:0]  sq_a;
  logic [4:0]  sq_b;

  assign a_clean      = clean_letter(letter_a);
  assign b_clean      = clean_letter(letter_b);
  assign place_letter = cmd.place_key ? a_clean : fill_k;

  // A letter goes into the next free cell only once, and only while cells remain.
  assign do_place = (cmd.place_key || (cmd.fill_step && fill_k != LETTER_J)) &&
                    !used_letters[place_letter] && (fill_count < CELLS);

  assign stat.key_ready = key_ready;
  assign stat.fill_last = (fill_k == LETTER_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      used_letters <= '0;
      fill_count   <= '0;
      key_ready    <= 1'b0;
      fill_k       <= '0;
    end else begin
      if (cmd.clear_key) begin
        used_letters <= '0;
        fill_count   <= '0;
        key_ready    <= 1'b0;
      end
      if (do_place) begin
        used_letters[place_letter] <= 1'b1;
        fill_count                 <= fill_count + 5'd1;
      end
      if (cmd.fill_begin) begin
        fill_k <= '0;
      end else if (cmd.fill_step) begin
        fill_k <= fill_k + 5'd1;
        if (stat.fill_last) begin
          key_ready <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_begin) begin
      dir_enc <= cmd.encrypt;
    end
  end

  pfc_ram #(
    .WIDTH(5),
    .DEPTH(LETTER_DEPTH)
  ) u_pos_ram (
    .clk    (clk),
    .we     (do_place),
    .waddr  (place_letter),
    .wdata  (fill_count),
    .re     (cmd.pair_begin),
    .raddr_a(a_clean),
    .raddr_b(b_clean),
    .rdata_a(pos_a),
    .rdata_b(pos_b)
  );

  assign ra = pos_row(pos_a);
  assign ca = pos_col(pos_a);
  assign rb = pos_row(pos_b);
  assign cb = pos_col(pos_b);

  // Equal letters share a row, so they take the row rule.
  always_comb begin
    if (ra == rb) begin
      cell_a = cell_index(ra, step_rc(ca, dir_enc));
      cell_b = cell_index(rb, step_rc(cb, dir_enc));
    end else if (ca == cb) begin
      cell_a = cell_index(step_rc(ra, dir_enc), ca);
      cell_b = cell_index(step_rc(rb, dir_enc), cb);
    end else begin
      cell_a = cell_index(ra, cb);
      cell_b = cell_index(rb, ca);
    end
  end

  pfc_ram #(
    .WIDTH(5),
    .DEPTH(CELL_DEPTH)
  ) u_square_ram (
    .clk    (clk),
    .we     (do_place),
    .waddr  (fill_count),
    .wdata  (place_letter),
    .re     (cmd.cell_read),
    .raddr_a(cell_a),
    .raddr_b(cell_b),
    .rdata_a(sq_a),
    .rdata_b(sq_b)
  );

  assign done   = cmd.result;
  assign out_a  = key_ready ? sq_a : 5'd0;
  assign out_b  = key_ready ? sq_b : 5'd0;
  assign status = !key_ready;

endmodule

// ===== rtl/core/pfc_ctrl.sv =====
// Controller: decodes requests and sequences pair lookups and the key fill walk.
module pfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     op,
  input  pfc_pkg::stat_t stat,
  output logic           busy,
  output pfc_pkg::cmd_t  cmd
);
  import pfc_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == ST_CELL) || (state == ST_FILL);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE, ST_RESULT: begin
        state_next = ST_IDLE;
        if (accept) begin
          unique case (op) inside
            OP_FINISH: begin
              state_next = stat.key_ready ? ST_IDLE : ST_FILL;
            end
            OP_ENCRYPT, OP_DECRYPT: begin
              state_next = ST_CELL;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_CELL: begin
        state_next = ST_RESULT;
      end
      ST_FILL: begin
        state_next = stat.fill_last ? ST_IDLE : ST_FILL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE, ST_RESULT: begin
        cmd.result = (state == ST_RESULT);
        if (accept) begin
          unique case (op) inside
            OP_START: begin
              cmd.clear_key = 1'b1;
            end
            OP_LETTER: begin
              cmd.place_key = !stat.key_ready;
            end
            OP_FINISH: begin
              cmd.fill_begin = !stat.key_ready;
            end
            OP_ENCRYPT, OP_DECRYPT: begin
              cmd.pair_begin = 1'b1;
              cmd.encrypt    = (op == OP_ENCRYPT);
            end
            default: begin
              cmd.pair_begin = 1'b0;
            end
          endcase
        end
      end
      ST_CELL: begin
        cmd.cell_read = 1'b1;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/playfair_pair_cipher.sv =====
// Playfair pair cipher: one request at a time; a pair result strobes done after the
// position lookup and the square lookup, each registered in its memory. A new pair
// can be accepted while done is high, not during the square lookup. Start key and
// key letter requests leave busy low; finish key, unless the key is finished, keeps
// busy high while it walks the alphabet. The receiver cannot stall the result.
// Synchronous reset clears the key state; the square is unusable until a key finishes.
module playfair_pair_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [4:0] letter_a,
  input  logic [4:0] letter_b,
  output logic       done,
  output logic [4:0] out_a,
  output logic [4:0] out_b,
  output logic       status
);
  import pfc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pfc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  pfc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .letter_a(letter_a),
    .letter_b(letter_b),
    .stat    (stat),
    .done    (done),
    .out_a   (out_a),
    .out_b   (out_b),
    .status  (status)
  );

endmodule

// ===== rtl/core/pfc_checker.sv =====
// Port-level checker for the Playfair pair cipher, bound to the top level.
`include "playfair_pair_cipher_defines.svh"

module pfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] op,
  input logic [4:0] letter_a,
  input logic [4:0] letter_b,
  input logic       done,
  input logic [4:0] out_a,
  input logic [4:0] out_b,
  input logic       status
);
  import pfc_pkg::*;

  logic pair_req;

  assign pair_req = start && !busy && !rst && ((op == OP_ENCRYPT) || (op == OP_DECRYPT));

  // Every result answers a pair request accepted before its position and square lookups,
  // and every such request gets its result unless reset intervenes.
  `PFC_ASSERT_IMP(a_done_has_request, done, $past(pair_req, 2))
  `PFC_ASSERT_IMP(a_request_gets_done, $past(pair_req, 2) && !$past(rst), done)
  `PFC_ASSERT_NEXT(a_pair_holds_busy, pair_req, busy)
  `PFC_ASSERT_IMP(a_unready_zero, done && status, (out_a == 5'd0) && (out_b == 5'd0))
  `PFC_ASSERT_IMP(a_equal_pair, done && !status && $past(letter_a == letter_b, 2),
                  out_a == out_b)

endmodule

bind playfair_pair_cipher pfc_checker u_pfc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .op      (op),
  .letter_a(letter_a),
  .letter_b(letter_b),
  .done    (done),
  .out_a   (out_a),
  .out_b   (out_b),
  .status  (status)
);

// ===== bench/playfair_pair_cipher_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Playfair pair cipher: key building and pair requests.
module playfair_pair_cipher_test;
  import pfc_pkg::*;

  localparam int ROW_LEN = int'(SIDE);
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
  localparam int RANDOM_REQUESTS = 1950;

  typedef struct packed {
    logic [4:0] out_a;
    logic [4:0] out_b;
    logic status;
  } pair_result_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] op;
  logic [4:0] letter_a;
  logic [4:0] letter_b;
  logic done;
  logic [4:0] out_a;
  logic [4:0] out_b;
  logic status;

  // Local copy of the key square and its lookup tables.
  logic [4:0] key_sq [CELL_DEPTH];
  logic [4:0] key_pos [LETTER_DEPTH];
  logic [25:0] key_used;
  int key_fill;
  bit key_done;

  pair_result_t pending_pairs[$];
  int fail_count;
  int sent_count;
  int pair_count;
  int unready_count;
  int key_count;
  bit burst_mode;

  playfair_pair_cipher dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .letter_a(letter_a),
    .letter_b(letter_b),
    .done(done),
    .out_a(out_a),
    .out_b(out_b),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("playfair_pair_cipher_test failed");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic logic [4:0] fold_letter(input logic [4:0] v);
    if (v > LETTER_Z) begin
      return LETTER_Z;
    end
    if (v == LETTER_J) begin
      return LETTER_I;
    end
    return v;
  endfunction

  task automatic place_key_letter(input logic [4:0] l);
    if (key_fill < CELL_DEPTH && !key_used[l]) begin
      key_sq[key_fill] = l;
      key_pos[l] = 5'(key_fill);
      key_used[l] = 1'b1;
      key_fill++;
    end
  endtask

  // Updates the local key state for one accepted request and queues any pair result.
  task automatic predict_cipher(input logic [2:0] op_v, input logic [4:0] a_v,
                                input logic [4:0] b_v);
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] oa;
    logic [4:0] ob;
    int ra;
    int ca;
    int rb;
    int cb;
    int sh;
    pair_result_t res;
    unique case (op_v) inside
      OP_START: begin
        key_used = '0;
        key_fill = 0;
        key_done = 1'b0;
      end
      OP_LETTER: begin
        if (!key_done) begin
          place_key_letter(fold_letter(a_v));
        end
      end
      OP_FINISH: begin
        if (!key_done) begin
          for (int k = 0; k < LETTER_DEPTH; k++) begin
            if (k != int'(LETTER_J)) begin
              place_key_letter(5'(k));
            end
          end
          key_done = 1'b1;
          key_count++;
        end
      end
      OP_ENCRYPT, OP_DECRYPT: begin
        if (!key_done) begin
          res = '{5'd0, 5'd0, 1'b1};
          unready_count++;
        end else begin
          a = fold_letter(a_v);
          b = fold_letter(b_v);
          ra = int'(key_pos[a]) / ROW_LEN;
          ca = int'(key_pos[a]) % ROW_LEN;
          rb = int'(key_pos[b]) / ROW_LEN;
          cb = int'(key_pos[b]) % ROW_LEN;
          sh = (op_v == OP_ENCRYPT) ? 1 : ROW_LEN - 1;
          if (ra == rb) begin
            oa = key_sq[ra * ROW_LEN + (ca + sh) % ROW_LEN];
            ob = key_sq[rb * ROW_LEN + (cb + sh) % ROW_LEN];
          end else if (ca == cb) begin
            oa = key_sq[((ra + sh) % ROW_LEN) * ROW_LEN + ca];
            ob = key_sq[((rb + sh) % ROW_LEN) * ROW_LEN + cb];
          end else begin
            oa = key_sq[ra * ROW_LEN + cb];
            ob = key_sq[rb * ROW_LEN + ca];
          end
          res = '{oa, ob, 1'b0};
          pair_count++;
        end
        pending_pairs.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [2:0] op_v, input logic [4:0] a_v,
                              input logic [4:0] b_v);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    op = op_v;
    letter_a = a_v;
    letter_b = b_v;
    do @(posedge clk); while (busy);
    predict_cipher(op_v, a_v, b_v);
    if (op_v <= OP_DECRYPT) begin
      sent_count++;
    end
    @(negedge clk);
  endtask

  function automatic logic [4:0] rand_letter();
    if ($urandom_range(0, 4) == 0) begin
      return 5'($urandom_range(0, 31));
    end
    return 5'($urandom_range(0, 25));
  endfunction

  function automatic logic [2:0] rand_cipher_op();
    return 3'($urandom_range(OP_ENCRYPT, OP_DECRYPT));
  endfunction

  always @(posedge clk) begin : result_check
    pair_result_t want;
    if (!rst && done) begin
      if (pending_pairs.size() == 0) begin
        note_failure($sformatf("unexpected result: a=%0d b=%0d status=%0d",
                               out_a, out_b, status));
      end else begin
        want = pending_pairs.pop_front();
        if (out_a !== want.out_a || out_b !== want.out_b || status !== want.status) begin
          note_failure($sformatf(
            "result mismatch: expected a=%0d b=%0d status=%0d, got a=%0d b=%0d status=%0d",
            want.out_a, want.out_b, want.status, out_a, out_b, status));
        end
      end
    end
  end

  task automatic test_unfinished_key();
    send_request(OP_ENCRYPT, 5'd0, 5'd25);
    send_request(OP_DECRYPT, 5'd31, 5'd9);
    for (int k = int'(OP_UNUSED_FIRST); k <= int'(OP_UNUSED_LAST); k++) begin
      send_request(3'(k), 5'd31, 5'd31);
    end
  endtask

  // The key is built from the reset state, without a start request.
  task automatic test_key_without_start();
    send_request(OP_LETTER, LETTER_J, 5'd31);
    send_request(OP_LETTER, 5'd31, 5'd0);
    send_request(OP_LETTER, 5'd0, 5'd21);
    send_request(OP_LETTER, 5'd25, 5'd10);
    send_request(OP_FINISH, 5'd0, 5'd0);
    send_request(OP_FINISH, 5'd17, 5'd3);
    send_request(OP_LETTER, 5'd16, 5'd16);
    send_request(OP_ENCRYPT, 5'd8, 5'd2);
    send_request(OP_DECRYPT, 5'd8, 5'd2);
    send_request(OP_ENCRYPT, 5'd3, 5'd15);
    send_request(OP_DECRYPT, 5'd3, 5'd15);
    send_request(OP_ENCRYPT, 5'd4, 5'd18);
    send_request(OP_DECRYPT, 5'd12, 5'd12);
    send_request(OP_ENCRYPT, LETTER_J, 5'd23);
    send_request(OP_DECRYPT, 5'd31, 5'd0);
  endtask

  task automatic test_restart_before_finish();
    send_request(OP_START, 5'd31, 5'd31);
    send_request(OP_ENCRYPT, 5'd7, 5'd19);
    send_request(OP_DECRYPT, 5'd0, 5'd0);
  endtask

  // One well-formed key session with random content, plus a little noise.
  task automatic run_key_session();
    logic [4:0] perm [CELL_DEPTH];
    logic [4:0] t;
    int n;
    int idx;
    int j;
    int r;
    burst_mode = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0) begin
      send_request(OP_START, rand_letter(), rand_letter());
    end
    if ($urandom_range(0, 7) == 0) begin
      // Every usable letter once, shuffled, then letters that find the square full.
      idx = 0;
      for (int k = 0; k < LETTER_DEPTH; k++) begin
        if (k != int'(LETTER_J)) begin
          perm[idx] = 5'(k);
          idx++;
        end
      end
      for (int k = CELL_DEPTH - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      for (int k = 0; k < CELL_DEPTH; k++) begin
        send_request(OP_LETTER, perm[k], rand_letter());
      end
      n = $urandom_range(1, 2);
      for (int k = 0; k < n; k++) begin
        send_request(OP_LETTER, rand_letter(), rand_letter());
      end
    end else begin
      n = $urandom_range(0, 12);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 11);
        if (r == 0) begin
          send_request(rand_cipher_op(), rand_letter(), rand_letter());
        end else if (r == 1) begin
          send_request(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                       rand_letter(), rand_letter());
        end else begin
          send_request(OP_LETTER, rand_letter(), rand_letter());
        end
      end
    end
    send_request(OP_FINISH, rand_letter(), rand_letter());
    if ($urandom_range(0, 3) == 0) begin
      send_request(($urandom_range(0, 1) == 0) ? OP_FINISH : OP_LETTER,
                   rand_letter(), rand_letter());
    end
    n = $urandom_range(4, 30);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_request(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                     rand_letter(), rand_letter());
      end else if (r == 1) begin
        send_request(OP_LETTER, rand_letter(), rand_letter());
      end else begin
        send_request(rand_cipher_op(), rand_letter(), rand_letter());
      end
    end
  endtask

  task automatic run_noise();
    int n;
    burst_mode = 1'b0;
    n = $urandom_range(3, 12);
    for (int k = 0; k < n; k++) begin
      send_request(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                   5'($urandom_range(0, 31)));
    end
  endtask

  task automatic test_random_sessions();
    int target;
    target = sent_count + RANDOM_REQUESTS;
    while (sent_count < target) begin
      if ($urandom_range(0, 9) == 0) begin
        run_noise();
      end else begin
        run_key_session();
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    start = 1'b0;
    op = OP_START;
    letter_a = 5'd0;
    letter_b = 5'd0;
    key_used = '0;
    key_fill = 0;
    key_done = 1'b0;
    burst_mode = 1'b0;
    fail_count = 0;
    sent_count = 0;
    pair_count = 0;
    unready_count = 0;
    key_count = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_unfinished_key();
    test_key_without_start();
    test_restart_before_finish();
    test_random_sessions();

    start = 1'b0;
    waited = 0;
    while (pending_pairs.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    // A finish request can still be walking the alphabet.
    repeat (40) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", pending_pairs.size()));
    end

    $display("Sent %0d requests; %0d keys finished.", sent_count, key_count);
    $display("Checked %0d pair results and %0d unfinished-key results; %0d failures.",
             pair_count, unready_count, fail_count);
    if (fail_count == 0) begin
      $display("playfair_pair_cipher_test passed");
    end else begin
      $display("playfair_pair_cipher_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pfc_pkg.sv
rtl/core/pfc_ram.sv
rtl/core/pfc_datapath.sv
rtl/core/pfc_ctrl.sv
rtl/core/playfair_pair_cipher.sv
rtl/core/pfc_checker.sv
bench/playfair_pair_cipher_test.sv
